// ----- hw/rtl/ptc_pkg.sv -----
`timescale 1ns / 1ps
package ptc_pkg;

    // Fixed constants of the compensation scheme
    localparam logic [31:0] C_PA_OFS    = 32'd64000;
    localparam logic [31:0] C_P_BASE    = 32'd1048576;
    localparam logic [31:0] C_P_SCALE   = 32'd3125;
    localparam logic [31:0] C_TEMP_RND  = 32'd128;
    localparam logic [31:0] C_P1_OFS    = 32'd32768;
    localparam logic [31:0] C_SIGN32    = 32'h8000_0000;
    localparam logic [19:0] C_PRESS_MAX = 20'hFFFFF;

    // Queue between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    // Front pipeline depth
    localparam int unsigned NST = 12;

    // Divider: 33-bit dividend, one quotient bit per stage, plus the load stage
    localparam int unsigned DIVW = 33;
    localparam int unsigned NDS  = DIVW + 1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CAL_TEMP    = 2'd0,
        CFG_CAL_PRESS_A = 2'd1,
        CFG_CAL_PRESS_B = 2'd2,
        CFG_CAL_PRESS_C = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_cal;

    // One transaction handed from front to back
    typedef struct packed {
        logic [15:0] temp;
        logic [31:0] num;
        logic [31:0] den;
        logic        valid;
    } t_qent;

    // Sign-extend a 16-bit coefficient
    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Product modulo 2^32 (low word is independent of operand signedness)
    function automatic logic [31:0] mulw(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] pr;
        pr = a * b;
        return pr;
    endfunction

    // Arithmetic shift right of a 32-bit word
    function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
        logic signed [31:0] s;
        s = $signed(v) >>> n;
        return s;
    endfunction

endpackage

// ----- hw/rtl/ptc_front.sv -----
`timescale 1ns / 1ps
module ptc_front
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cal        i_cal,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [19:0] i_raw_temp,
    input  logic [19:0] i_raw_press,
    output logic        o_push,
    input  logic        i_full,
    output t_qent       o_ent
);

    logic [NST-1:0] r_vld;
    logic           en;

    logic [19:0] r0_t, r0_p, r1_p, r2_p, r3_p, r4_p, r5_p, r6_p, r7_p, r8_p, r9_p;
    logic [31:0] r1_x1, r1_d;
    logic [31:0] r2_m1, r2_dd;
    logic [31:0] r3_a, r3_m2;
    logic [31:0] r4_fine;
    logic [31:0] r5_t5, r5_pa;
    logic [15:0] r6_temp, r7_temp, r8_temp, r9_temp, r10_temp, r11_temp;
    logic [31:0] r6_qq, r6_pa5, r6_p2a;
    logic [31:0] r7_b1, r7_p3q, r7_pa5, r7_p2a;
    logic [31:0] r8_b2, r8_a1;
    logic [31:0] r9_b3, r9_a2;
    logic [31:0] r10_den, r10_pr;
    logic [31:0] r11_num, r11_den;

    logic [31:0] c_ts, c_q, c_qqs;

    // Whole front advances together; stops only when its last slot cannot drain
    assign en      = !r_vld[NST-1] || !i_full;
    assign o_ready = en;
    assign o_push  = r_vld[NST-1] && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_comb begin
        c_ts  = asr(r5_t5, 8);
        c_q   = asr(r5_pa, 2);
        c_qqs = r6_qq;
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            // capture
            r0_t <= i_raw_temp;
            r0_p <= i_raw_press;
            // temperature terms
            r1_x1 <= {15'b0, r0_t[19:3]} - {15'b0, i_cal.t1, 1'b0};
            r1_d  <= {16'b0, r0_t[19:4]} - {16'b0, i_cal.t1};
            r1_p  <= r0_p;
            r2_m1 <= mulw(r1_x1, sx16(i_cal.t2));
            r2_dd <= mulw(r1_d, r1_d);
            r2_p  <= r1_p;
            r3_a  <= asr(r2_m1, 11);
            r3_m2 <= mulw(asr(r2_dd, 12), sx16(i_cal.t3));
            r3_p  <= r2_p;
            r4_fine <= r3_a + asr(r3_m2, 14);
            r4_p    <= r3_p;
            r5_t5 <= mulw(r4_fine, 32'd5) + C_TEMP_RND;
            r5_pa <= asr(r4_fine, 1) - C_PA_OFS;
            r5_p  <= r4_p;
            // temperature saturation and first pressure products
            if ($signed(c_ts) > 32'sd32767) begin
                r6_temp <= 16'h7FFF;
            end else if ($signed(c_ts) < -32'sd32768) begin
                r6_temp <= 16'h8000;
            end else begin
                r6_temp <= c_ts[15:0];
            end
            r6_qq  <= mulw(c_q, c_q);
            r6_pa5 <= mulw(mulw(r5_pa, sx16(i_cal.p5)), 32'd2);
            r6_p2a <= mulw(sx16(i_cal.p2), r5_pa);
            r6_p   <= r5_p;
            r7_b1   <= mulw(asr(c_qqs, 11), sx16(i_cal.p6));
            r7_p3q  <= mulw(sx16(i_cal.p3), asr(c_qqs, 13));
            r7_pa5  <= r6_pa5;
            r7_p2a  <= r6_p2a;
            r7_temp <= r6_temp;
            r7_p    <= r6_p;
            r8_b2   <= r7_b1 + r7_pa5;
            r8_a1   <= asr(asr(r7_p3q, 3) + asr(r7_p2a, 1), 18);
            r8_temp <= r7_temp;
            r8_p    <= r7_p;
            r9_b3   <= asr(r8_b2, 2) + {i_cal.p4, 16'b0};
            r9_a2   <= mulw(C_P1_OFS + r8_a1, {16'b0, i_cal.p1});
            r9_temp <= r8_temp;
            r9_p    <= r8_p;
            // denominator and numerator
            r10_den  <= asr(r9_a2, 15);
            r10_pr   <= (C_P_BASE - {12'b0, r9_p}) - asr(r9_b3, 12);
            r10_temp <= r9_temp;
            r11_num  <= mulw(r10_pr, C_P_SCALE);
            r11_den  <= r10_den;
            r11_temp <= r10_temp;
        end
    end

    // Classify: zero denominator marks the pressure invalid
    always_comb begin
        o_ent.temp  = r11_temp;
        o_ent.num   = r11_num;
        o_ent.den   = r11_den;
        o_ent.valid = (r11_den != '0);
    end

endmodule

// ----- hw/rtl/ptc_queue.sv -----
`timescale 1ns / 1ps
module ptc_queue
    import ptc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_ent,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_qent o_ent
);

    t_qent          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_ent   = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

endmodule

// ----- hw/rtl/ptc_back.sv -----
`timescale 1ns / 1ps
module ptc_back
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cal        i_cal,
    input  logic        i_empty,
    input  t_qent       i_ent,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_temp_centi,
    output logic [19:0] o_press_pa,
    output logic        o_pressure_valid
);

    logic en;

    // Divider pipeline, one quotient bit per stage
    logic [NDS-1:0]  r_dvld;
    logic [DIVW-1:0] r_dn  [NDS];
    logic [DIVW-1:0] r_qt  [NDS];
    logic [31:0]     r_rm  [NDS];
    logic [31:0]     r_dv  [NDS];
    logic            r_lo  [NDS];
    logic            r_ok  [NDS];
    logic [15:0]     r_tp  [NDS];
    logic [DIVW-1:0] c_rs  [NDS-1];
    logic            c_ge  [NDS-1];

    logic [2:0]  r_vld;
    logic [31:0] r1_p, r1_sq, r1_pp8;
    logic [31:0] r2_p, r2_a, r2_b;
    logic [15:0] r1_tp, r2_tp;
    logic        r1_ok, r2_ok;
    logic [31:0] c_pd, c_s;
    logic [33:0] c_press;

    assign en    = !r_vld[2] || i_ready;
    assign o_pop = en && !i_empty;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld <= '0;
            r_vld  <= '0;
        end else if (en) begin
            r_dvld <= {r_dvld[NDS-2:0], !i_empty};
            r_vld  <= {r_vld[1:0], r_dvld[NDS-1]};
        end
    end

    // Trial subtraction for every divider stage
    always_comb begin
        for (int k = 0; k < NDS - 1; k++) begin
            c_rs[k] = {r_rm[k], r_dn[k][DIVW-1]};
            c_ge[k] = (c_rs[k] >= {1'b0, r_dv[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // load: below half range divide 2p, else divide p and double later
            r_dn[0] <= i_ent.num[31] ? {1'b0, i_ent.num} : {i_ent.num, 1'b0};
            r_lo[0] <= !i_ent.num[31];
            r_qt[0] <= '0;
            r_rm[0] <= '0;
            r_dv[0] <= i_ent.den;
            r_ok[0] <= i_ent.valid;
            r_tp[0] <= i_ent.temp;
            for (int k = 0; k < NDS - 1; k++) begin
                r_dn[k+1] <= r_dn[k] << 1;
                r_qt[k+1] <= {r_qt[k][DIVW-2:0], c_ge[k]};
                r_rm[k+1] <= c_ge[k] ? 32'(c_rs[k] - {1'b0, r_dv[k]}) : c_rs[k][31:0];
                r_dv[k+1] <= r_dv[k];
                r_lo[k+1] <= r_lo[k];
                r_ok[k+1] <= r_ok[k];
                r_tp[k+1] <= r_tp[k];
            end
        end
    end

    always_comb begin
        c_pd = r_lo[NDS-1] ? r_qt[NDS-1][31:0] : {r_qt[NDS-1][30:0], 1'b0};
        c_s  = asr(r2_a + r2_b + sx16(i_cal.p7), 4);
        c_press = {2'b0, r2_p} + {{2{c_s[31]}}, c_s};
    end

    // Correction terms and output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p   <= c_pd;
            r1_sq  <= mulw({3'b0, c_pd[31:3]}, {3'b0, c_pd[31:3]});
            r1_pp8 <= mulw({2'b0, c_pd[31:2]}, sx16(i_cal.p8));
            r1_tp  <= r_tp[NDS-1];
            r1_ok  <= r_ok[NDS-1];
            r2_p   <= r1_p;
            r2_a   <= asr(mulw(sx16(i_cal.p9), {13'b0, r1_sq[31:13]}), 12);
            r2_b   <= asr(r1_pp8, 13);
            r2_tp  <= r1_tp;
            r2_ok  <= r1_ok;
            o_temp_centi     <= r2_tp;
            o_pressure_valid <= r2_ok;
            if (!r2_ok || c_press[33]) begin
                o_press_pa <= '0;
            end else if (c_press[32:20] != '0) begin
                o_press_pa <= C_PRESS_MAX;
            end else begin
                o_press_pa <= c_press[19:0];
            end
        end
    end

    assign o_valid = r_vld[2];

endmodule

// ----- hw/rtl/pressure_temperature_compensation.sv -----
`timescale 1ns / 1ps
// Barometric temperature and pressure compensation, 32-bit integer scheme.
// Slave stream: i_s_tdata carries raw_temp [19:0] and raw_press [39:20].
// Master stream: o_m_tdata carries temp_centi [15:0] (0.01 degC, signed) and
// press_pa [35:16] (Pa); o_m_tuser[0] is pressure_valid.
// Calibration is written through i_cfg_valid/i_cfg_index/i_cfg_data while
// the block is idle: index 0 temperature words, 1 and 2 pressure words P1-P8,
// 3 the P9 word. o_cfg_ready is always high.
// Throughput is one transaction per cycle while the receiver does not stall.
// o_m_tvalid rises after 50 register stages: 12 front stages (the first loads
// at the accepting edge), the queue storage, 34 stages of the restoring divider
// (a load stage, then one quotient bit each) and 3 correction and output stages.
// Reset clears the pipeline valid bits, the queue and the calibration words.
// When the receiver stalls the back end holds; the front keeps accepting
// until the four-entry queue is full and a transaction sits in its last
// stage, then the whole front holds, bubbles included, and drops o_s_tready.
module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // raw_temp [19:0], raw_press [39:20]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // temp_centi [15:0], press_pa [35:16], zero pad
    output logic [0:0]  o_m_tuser,   // pressure_valid [0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [47:0] r_cal_temp;
    logic [63:0] r_cal_press_a, r_cal_press_b;
    logic [15:0] r_cal_press_c;
    t_cal        cal;

    logic  q_push, q_pop, q_full, q_empty;
    t_qent q_in, q_out;

    logic [15:0] temp_centi;
    logic [19:0] press_pa;
    logic        press_ok;

    assign o_cfg_ready = 1'b1;

    // Calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_temp    <= '0;
            r_cal_press_a <= '0;
            r_cal_press_b <= '0;
            r_cal_press_c <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CAL_TEMP:    r_cal_temp    <= i_cfg_data[47:0];
                CFG_CAL_PRESS_A: r_cal_press_a <= i_cfg_data;
                CFG_CAL_PRESS_B: r_cal_press_b <= i_cfg_data;
                CFG_CAL_PRESS_C: r_cal_press_c <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cal.t1 = r_cal_temp[15:0];
        cal.t2 = r_cal_temp[31:16];
        cal.t3 = r_cal_temp[47:32];
        cal.p1 = r_cal_press_a[15:0];
        cal.p2 = r_cal_press_a[31:16];
        cal.p3 = r_cal_press_a[47:32];
        cal.p4 = r_cal_press_a[63:48];
        cal.p5 = r_cal_press_b[15:0];
        cal.p6 = r_cal_press_b[31:16];
        cal.p7 = r_cal_press_b[47:32];
        cal.p8 = r_cal_press_b[63:48];
        cal.p9 = r_cal_press_c;
    end

    ptc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cal       (cal),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_raw_temp  (i_s_tdata[19:0]),
        .i_raw_press (i_s_tdata[39:20]),
        .o_push      (q_push),
        .i_full      (q_full),
        .o_ent       (q_in)
    );

    ptc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_ent   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_ent   (q_out)
    );

    ptc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cal            (cal),
        .i_empty          (q_empty),
        .i_ent            (q_out),
        .o_pop            (q_pop),
        .o_valid          (o_m_tvalid),
        .i_ready          (i_m_tready),
        .o_temp_centi     (temp_centi),
        .o_press_pa       (press_pa),
        .o_pressure_valid (press_ok)
    );

    assign o_m_tdata = {4'b0, press_pa, temp_centi};
    assign o_m_tuser = press_ok;

    // An invalid pressure always reads as zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata[35:16] == '0)
        else $error("invalid pressure with nonzero value");

    // No result straight out of reset
    assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // Queue starts empty after reset
    assert property (@(posedge i_clk) !i_rst_n |=> q_empty)
        else $error("queue not empty after reset");

    // Queue never written while full nor read while empty
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full) && !(q_pop && q_empty))
        else $error("queue overflow or underflow");

endmodule
